/* hdl/bhlc_pkg.sv */
// bhlc_pkg: shared types, register indexes, color codes and hsv bands
// for the box hsv light color classifier; no dependencies
package bhlc_pkg;

    localparam int IMG_BITS   = 13;
    localparam int COUNT_BITS = 25;
    localparam int INDEX_BITS = 3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // configuration register indexes
    localparam logic [INDEX_BITS-1:0] REG_BOX_COUNT    = 3'd0;
    localparam logic [INDEX_BITS-1:0] REG_BOX_FIRST    = 3'd1;
    localparam logic [INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd5;
    localparam logic [INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd6;
    localparam int                    NUM_BOX_REGS     = 4;

    localparam logic [IMG_BITS-1:0] IMAGE_WIDTH_RESET  = 13'd640;
    localparam logic [IMG_BITS-1:0] IMAGE_HEIGHT_RESET = 13'd480;

    // verdict codes
    localparam logic [1:0] COLOR_UNKNOWN = 2'd0;
    localparam logic [1:0] COLOR_RED     = 2'd1;
    localparam logic [1:0] COLOR_YELLOW  = 2'd2;
    localparam logic [1:0] COLOR_GREEN   = 2'd3;

    typedef struct packed {
        logic [7:0]  hue;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
        logic [11:0] column;
        logic [11:0] row;
        logic        frame_end;
    } pixel_t;

    typedef struct packed {
        logic [1:0] box_index;
        logic [1:0] light_color;
        logic       last_result;
    } result_t;

    // pixel token handed from cell to cell
    typedef struct packed {
        logic        valid;
        logic        is_r;
        logic        is_y;
        logic        is_g;
        logic [11:0] column;
        logic [11:0] row;
        logic        frame_end;
    } token_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] color;
    } verdict_t;

    typedef struct packed {
        logic [7:0] lo_h;
        logic [7:0] lo_s;
        logic [7:0] lo_v;
        logic [7:0] hi_h;
        logic [7:0] hi_s;
        logic [7:0] hi_v;
    } hsv_band_t;

    localparam hsv_band_t BAND_RED_A  = '{8'd0,   8'd120, 8'd200, 8'd10,  8'd255, 8'd255};
    localparam hsv_band_t BAND_RED_B  = '{8'd170, 8'd120, 8'd200, 8'd179, 8'd255, 8'd255};
    localparam hsv_band_t BAND_YELLOW = '{8'd25,  8'd140, 8'd200, 8'd35,  8'd225, 8'd255};
    localparam hsv_band_t BAND_GREEN  = '{8'd40,  8'd130, 8'd200, 8'd80,  8'd245, 8'd255};

    function automatic logic in_band(input hsv_band_t b, input logic [7:0] h,
                                     input logic [7:0] s, input logic [7:0] v);
        in_band = (h >= b.lo_h) && (h <= b.hi_h) &&
                  (s >= b.lo_s) && (s <= b.hi_s) &&
                  (v >= b.lo_v) && (v <= b.hi_v);
    endfunction

endpackage

/* hdl/bhlc_cell.sv */
// bhlc_cell: one box of the chain; clips the box, counts colored pixels
// and writes its verdict into the verdict vector; depends on bhlc_pkg
module bhlc_cell #(
    parameter int COORD_BITS = 12,
    parameter int MAX_BOXES  = 4,
    parameter int CELL_INDEX = 0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [4*COORD_BITS-1:0]              box,
    input  logic                                 box_on,
    input  logic [bhlc_pkg::IMG_BITS-1:0]        image_width,
    input  logic [bhlc_pkg::IMG_BITS-1:0]        image_height,
    input  bhlc_pkg::token_t                     tok_in,
    input  bhlc_pkg::verdict_t [MAX_BOXES-1:0]   vdt_in,
    output bhlc_pkg::token_t                     tok_out,
    output bhlc_pkg::verdict_t [MAX_BOXES-1:0]   vdt_out
);
    import bhlc_pkg::*;

    localparam int CW = (COORD_BITS + 1 > IMG_BITS) ? COORD_BITS + 1 : IMG_BITS;

    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [COORD_BITS-1:0] box_wid;
    logic [COORD_BITS-1:0] box_hgt;
    logic [COORD_BITS:0]   right_sum;
    logic [COORD_BITS:0]   bottom_sum;
    logic [CW-1:0]         x0, x1, y0, y1, xw, yh, col_x, row_y;
    logic                  nonempty;
    logic                  hit;
    logic                  frame_done;

    logic [COUNT_BITS-1:0] red_reg, red_bump, red_next;
    logic [COUNT_BITS-1:0] yel_reg, yel_bump, yel_next;
    logic [COUNT_BITS-1:0] grn_reg, grn_bump, grn_next;
    logic [1:0]            color;

    token_t                    tok_reg;
    verdict_t [MAX_BOXES-1:0]  vdt_reg, vdt_next;

    assign box_left = box[COORD_BITS-1:0];
    assign box_top  = box[2*COORD_BITS-1:COORD_BITS];
    assign box_wid  = box[3*COORD_BITS-1:2*COORD_BITS];
    assign box_hgt  = box[4*COORD_BITS-1:3*COORD_BITS];

    assign right_sum  = {1'b0, box_left} + {1'b0, box_wid};
    assign bottom_sum = {1'b0, box_top} + {1'b0, box_hgt};

    assign x0    = CW'(box_left);
    assign y0    = CW'(box_top);
    assign x1    = CW'(right_sum);
    assign y1    = CW'(bottom_sum);
    assign xw    = CW'(image_width);
    assign yh    = CW'(image_height);
    assign col_x = CW'(tok_in.column);
    assign row_y = CW'(tok_in.row);

    // min(right, width) > left splits into two compares
    assign nonempty = box_on && (x1 > x0) && (xw > x0) && (y1 > y0) && (yh > y0);

    assign hit = tok_in.valid && nonempty &&
                 (col_x >= x0) && (col_x < x1) && (col_x < xw) &&
                 (row_y >= y0) && (row_y < y1) && (row_y < yh);

    assign frame_done = tok_in.valid && tok_in.frame_end;

    always_comb
    begin
        red_bump = red_reg;
        yel_bump = yel_reg;
        grn_bump = grn_reg;
        if (hit && tok_in.is_r && red_reg != COUNT_MAX)
        begin
            red_bump = red_reg + 1'b1;
        end
        if (hit && tok_in.is_y && yel_reg != COUNT_MAX)
        begin
            yel_bump = yel_reg + 1'b1;
        end
        if (hit && tok_in.is_g && grn_reg != COUNT_MAX)
        begin
            grn_bump = grn_reg + 1'b1;
        end
        red_next = frame_done ? '0 : red_bump;
        yel_next = frame_done ? '0 : yel_bump;
        grn_next = frame_done ? '0 : grn_bump;
    end

    // strict winner on the counts that include the frame's last pixel
    always_comb
    begin
        priority if (red_bump > yel_bump && red_bump > grn_bump)
        begin
            color = COLOR_RED;
        end
        else if (yel_bump > red_bump && yel_bump > grn_bump)
        begin
            color = COLOR_YELLOW;
        end
        else if (grn_bump > red_bump && grn_bump > yel_bump)
        begin
            color = COLOR_GREEN;
        end
        else
        begin
            color = COLOR_UNKNOWN;
        end
    end

    always_comb
    begin
        vdt_next = vdt_in;
        if (frame_done)
        begin
            vdt_next[CELL_INDEX].ok    = nonempty;
            vdt_next[CELL_INDEX].color = color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg <= '0;
            yel_reg <= '0;
            grn_reg <= '0;
            tok_reg <= '0;
        end
        else
        begin
            red_reg <= red_next;
            yel_reg <= yel_next;
            grn_reg <= grn_next;
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        vdt_reg <= vdt_next;
    end

    assign tok_out = tok_reg;
    assign vdt_out = vdt_reg;

endmodule

/* hdl/bhlc_drain.sv */
// bhlc_drain: takes the verdict vector of a finished frame and hands out
// one result per usable box in box order; depends on bhlc_pkg
module bhlc_drain #(
    parameter int MAX_BOXES = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                frame_in,
    input  bhlc_pkg::verdict_t [MAX_BOXES-1:0]  vdt_in,
    output logic                                busy,
    output logic                                res_valid,
    input  logic                                res_stall,
    output bhlc_pkg::result_t                   res
);
    import bhlc_pkg::*;

    logic [MAX_BOXES-1:0] pend_reg;
    logic [1:0]           color_reg [MAX_BOXES];
    logic                 out_valid_reg;
    result_t              out_reg;

    logic [MAX_BOXES-1:0] first_oh;
    logic [1:0]           sel_color;
    logic [1:0]           sel_index;
    logic                 found;
    logic                 advance;
    logic [MAX_BOXES-1:0] pend_rest;

    // lowest pending box
    always_comb
    begin
        found     = 1'b0;
        first_oh  = '0;
        sel_color = COLOR_UNKNOWN;
        sel_index = 2'd0;
        for (int i = 0; i < MAX_BOXES; i++)
        begin
            if (pend_reg[i] && !found)
            begin
                found       = 1'b1;
                first_oh[i] = 1'b1;
                sel_color   = color_reg[i];
                sel_index   = 2'(i);
            end
        end
    end

    assign pend_rest = pend_reg & ~first_oh;
    assign advance   = !out_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (frame_in)
        begin
            for (int i = 0; i < MAX_BOXES; i++)
            begin
                pend_reg[i] <= vdt_in[i].ok;
            end
        end
        else if (advance)
        begin
            out_valid_reg <= found;
            pend_reg      <= pend_rest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_in)
        begin
            for (int i = 0; i < MAX_BOXES; i++)
            begin
                color_reg[i] <= vdt_in[i].color;
            end
        end
        if (!frame_in && advance && found)
        begin
            out_reg.box_index   <= sel_index;
            out_reg.light_color <= sel_color;
            out_reg.last_result <= (pend_rest == '0);
        end
    end

    assign busy      = out_valid_reg || (pend_reg != '0);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        frame_in |-> (pend_reg == '0) && !out_valid_reg)
        else $error("verdict vector arrived while results still pending");

    a_last_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.last_result |-> (pend_reg == '0))
        else $error("last result shown with boxes still pending");

    a_rise_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(pend_reg) != '0))
        else $error("result raised with nothing pending");

endmodule

/* hdl/box_hsv_light_color_classifier_core.sv */
// box_hsv_light_color_classifier_core: pixel classification, config
// registers, chain of box cells and result drain; depends on bhlc_pkg,
// bhlc_cell and bhlc_drain
// throughput: one pixel transfer per cycle unless a frame_end pixel is held off; each pixel walks one cell per cycle
// results: after the frame_end token passes the input and cell registers, the
//   drain loads the verdicts; results follow one per cycle while res_stall is low
// a frame_end pixel is held off while the previous frame's token is in the
//   chain or its results are not all taken
// reset: counters cleared, box_count 0, boxes 0, image size 640 x 480
module box_hsv_light_color_classifier_core #(
    parameter int MAX_BOXES  = 4,
    parameter int COORD_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [bhlc_pkg::INDEX_BITS-1:0]    cfg_index,
    input  logic [4*COORD_BITS-1:0]            cfg_data,
    input  logic                               pix_valid,
    output logic                               pix_stall,
    input  bhlc_pkg::pixel_t                   pix,
    output logic                               res_valid,
    input  logic                               res_stall,
    output bhlc_pkg::result_t                  res
);
    import bhlc_pkg::*;

    localparam int BOX_BITS = 4 * COORD_BITS;

    logic [2:0]            box_count_reg;
    logic [BOX_BITS-1:0]   boxes_reg [MAX_BOXES];
    logic [IMG_BITS-1:0]   image_width_reg;
    logic [IMG_BITS-1:0]   image_height_reg;

    token_t                    tok_w [MAX_BOXES+1];
    verdict_t [MAX_BOXES-1:0]  vdt_w [MAX_BOXES+1];
    token_t                    tok0_reg;
    token_t                    tok0_next;
    logic [MAX_BOXES:0]        frame_tok;
    logic                      drain_busy;
    logic                      frame_busy;
    logic                      pix_xfer;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_count_reg    <= 3'd0;
            image_width_reg  <= IMAGE_WIDTH_RESET;
            image_height_reg <= IMAGE_HEIGHT_RESET;
            for (int b = 0; b < MAX_BOXES; b++)
            begin
                boxes_reg[b] <= '0;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_BOX_COUNT)
            begin
                box_count_reg <= cfg_data[2:0];
            end
            if (cfg_index == REG_IMAGE_WIDTH)
            begin
                image_width_reg <= cfg_data[IMG_BITS-1:0];
            end
            if (cfg_index == REG_IMAGE_HEIGHT)
            begin
                image_height_reg <= cfg_data[IMG_BITS-1:0];
            end
            // boxes beyond the four box registers stay empty
            for (int b = 0; b < MAX_BOXES; b++)
            begin
                if (b < NUM_BOX_REGS && cfg_index == REG_BOX_FIRST + INDEX_BITS'(b))
                begin
                    boxes_reg[b] <= cfg_data;
                end
            end
        end
    end

    // input stage: classify and register the pixel
    assign pix_xfer = pix_valid && !pix_stall;

    always_comb
    begin
        tok0_next.valid     = pix_xfer;
        tok0_next.is_r      = in_band(BAND_RED_A, pix.hue, pix.saturation, pix.brightness) ||
                              in_band(BAND_RED_B, pix.hue, pix.saturation, pix.brightness);
        tok0_next.is_y      = in_band(BAND_YELLOW, pix.hue, pix.saturation, pix.brightness);
        tok0_next.is_g      = in_band(BAND_GREEN, pix.hue, pix.saturation, pix.brightness);
        tok0_next.column    = pix.column;
        tok0_next.row       = pix.row;
        tok0_next.frame_end = pix.frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok0_reg <= '0;
        end
        else
        begin
            tok0_reg <= tok0_next;
        end
    end

    assign tok_w[0] = tok0_reg;
    assign vdt_w[0] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_BOXES; g++)
        begin : g_cell
            logic box_on;
            assign box_on = {2'b00, box_count_reg} > 5'(g);

            bhlc_cell #(
                .COORD_BITS (COORD_BITS),
                .MAX_BOXES  (MAX_BOXES),
                .CELL_INDEX (g)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .box          (boxes_reg[g]),
                .box_on       (box_on),
                .image_width  (image_width_reg),
                .image_height (image_height_reg),
                .tok_in       (tok_w[g]),
                .vdt_in       (vdt_w[g]),
                .tok_out      (tok_w[g+1]),
                .vdt_out      (vdt_w[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        for (int k = 0; k <= MAX_BOXES; k++)
        begin
            frame_tok[k] = tok_w[k].valid && tok_w[k].frame_end;
        end
    end

    bhlc_drain #(
        .MAX_BOXES (MAX_BOXES)
    ) u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_in  (frame_tok[MAX_BOXES]),
        .vdt_in    (vdt_w[MAX_BOXES]),
        .busy      (drain_busy),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // one frame token in flight at a time; plain pixels always pass
    assign frame_busy = (frame_tok != '0) || drain_busy;
    assign pix_stall  = pix.frame_end && frame_busy;

    a_frame_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        pix_xfer && pix.frame_end |=> frame_busy)
        else $error("frame_end transfer not tracked as busy");

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(frame_tok) <= 1)
        else $error("more than one frame token in the chain");

    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> pix.frame_end && frame_busy)
        else $error("pixel stalled without a pending frame");

endmodule

/* sim/tb_box_hsv_light_color_classifier_core.sv */
// tb_box_hsv_light_color_classifier_core: self-checking bench for the box hsv
// light color classifier; a tally class predicts verdicts per frame and checks
// them in order; depends on bhlc_pkg and box_hsv_light_color_classifier_core
`timescale 1ns / 100ps

module tb_box_hsv_light_color_classifier_core;

    import bhlc_pkg::*;

    localparam int NUM_BOXES       = 4;
    localparam int COORD_W         = 12;
    localparam int CLK_PERIOD      = 12;
    localparam int DRAIN_CYCLES    = NUM_BOXES + 12;
    localparam int HOLD_CYCLES     = 160;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_PIXELS    = 33;
    localparam int PRESSURE_PHASE  = 5;
    localparam int PAUSE_PHASE     = 7;
    localparam int QUIET_PHASE     = 10;
    localparam int unsigned COUNT_TOP = (1 << COUNT_BITS) - 1;

    localparam logic [INDEX_BITS-1:0] REG_UNUSED = 3'd7;

    // pixel kinds used by the generator
    localparam int KIND_RED_A  = 0;
    localparam int KIND_RED_B  = 1;
    localparam int KIND_YELLOW = 2;
    localparam int KIND_GREEN  = 3;
    localparam int KIND_NOISE  = 4;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [INDEX_BITS-1:0]     cfg_index;
    logic [4*COORD_W-1:0]      cfg_data;
    logic                      pix_valid;
    logic                      pix_stall;
    pixel_t                    pix;
    logic                      res_valid;
    logic                      res_stall;
    result_t                   res;

    bit quiet;
    bit long_hold;
    int stuck_cycles;

    class light_tally;
        logic [2:0]          box_count;
        logic [4*COORD_W-1:0] boxes [NUM_BOXES];
        logic [IMG_BITS-1:0] img_w;
        logic [IMG_BITS-1:0] img_h;
        int unsigned         red_n [NUM_BOXES];
        int unsigned         yel_n [NUM_BOXES];
        int unsigned         grn_n [NUM_BOXES];
        result_t             pending_verdicts [$];
        int                  errors;

        function new();
            box_count = '0;
            img_w     = IMAGE_WIDTH_RESET;
            img_h     = IMAGE_HEIGHT_RESET;
            errors    = 0;
            for (int i = 0; i < NUM_BOXES; i++)
            begin
                boxes[i] = '0;
                red_n[i] = 0;
                yel_n[i] = 0;
                grn_n[i] = 0;
            end
        endfunction

        function void write_reg(logic [INDEX_BITS-1:0] idx, logic [4*COORD_W-1:0] d);
            if (idx == REG_BOX_COUNT)
                box_count = d[2:0];
            else if (idx == REG_IMAGE_WIDTH)
                img_w = d[IMG_BITS-1:0];
            else if (idx == REG_IMAGE_HEIGHT)
                img_h = d[IMG_BITS-1:0];
            else if (idx >= REG_BOX_FIRST && idx < REG_BOX_FIRST + NUM_BOX_REGS)
                boxes[idx - REG_BOX_FIRST] = d;
        endfunction

        function bit hsv_hit(hsv_band_t b, logic [7:0] h, logic [7:0] s, logic [7:0] v);
            bit h_ok;
            bit s_ok;
            bit v_ok;
            h_ok = !(h < b.lo_h || h > b.hi_h);
            s_ok = !(s < b.lo_s || s > b.hi_s);
            v_ok = !(v < b.lo_v || v > b.hi_v);
            return h_ok && s_ok && v_ok;
        endfunction

        // clipped span [x0,x1) x [y0,y1); zero when empty
        function bit clip_span(int i, output int unsigned x0, output int unsigned x1,
                               output int unsigned y0, output int unsigned y1);
            x0 = boxes[i][COORD_W-1:0];
            y0 = boxes[i][2*COORD_W-1:COORD_W];
            x1 = x0 + boxes[i][3*COORD_W-1:2*COORD_W];
            y1 = y0 + boxes[i][4*COORD_W-1:3*COORD_W];
            if (x1 > img_w)
                x1 = img_w;
            if (y1 > img_h)
                y1 = img_h;
            return (x1 > x0) && (y1 > y0);
        endfunction

        function logic [1:0] winner(int i);
            if (red_n[i] > yel_n[i] && red_n[i] > grn_n[i])
                return COLOR_RED;
            if (yel_n[i] > red_n[i] && yel_n[i] > grn_n[i])
                return COLOR_YELLOW;
            if (grn_n[i] > red_n[i] && grn_n[i] > yel_n[i])
                return COLOR_GREEN;
            return COLOR_UNKNOWN;
        endfunction

        function int unsigned bump(int unsigned c);
            return (c < COUNT_TOP) ? c + 1 : c;
        endfunction

        function void note_pixel(pixel_t p);
            bit          is_r;
            bit          is_y;
            bit          is_g;
            int unsigned x0;
            int unsigned x1;
            int unsigned y0;
            int unsigned y1;
            int          active;
            int          last_box;
            result_t     v;
            is_r = hsv_hit(BAND_RED_A, p.hue, p.saturation, p.brightness) ||
                   hsv_hit(BAND_RED_B, p.hue, p.saturation, p.brightness);
            is_y = hsv_hit(BAND_YELLOW, p.hue, p.saturation, p.brightness);
            is_g = hsv_hit(BAND_GREEN, p.hue, p.saturation, p.brightness);
            active = (box_count > NUM_BOXES) ? NUM_BOXES : box_count;
            for (int i = 0; i < active; i++)
            begin
                if (clip_span(i, x0, x1, y0, y1) &&
                    p.column >= x0 && p.column < x1 && p.row >= y0 && p.row < y1)
                begin
                    if (is_r)
                        red_n[i] = bump(red_n[i]);
                    if (is_y)
                        yel_n[i] = bump(yel_n[i]);
                    if (is_g)
                        grn_n[i] = bump(grn_n[i]);
                end
            end
            if (!p.frame_end)
                return;
            last_box = -1;
            for (int i = 0; i < active; i++)
            begin
                if (clip_span(i, x0, x1, y0, y1))
                    last_box = i;
            end
            for (int i = 0; i < active; i++)
            begin
                if (clip_span(i, x0, x1, y0, y1))
                begin
                    v.box_index   = i[1:0];
                    v.light_color = winner(i);
                    v.last_result = (i == last_box);
                    pending_verdicts.push_back(v);
                end
            end
            for (int i = 0; i < NUM_BOXES; i++)
            begin
                red_n[i] = 0;
                yel_n[i] = 0;
                grn_n[i] = 0;
            end
        endfunction

        task report(string what);
            errors++;
            $display("%0t mismatch: %s", $time, what);
        endtask

        task check_verdict(result_t r);
            result_t e;
            if (pending_verdicts.size() == 0)
            begin
                report($sformatf("unexpected verdict box %0d color %0d last %0b",
                                 r.box_index, r.light_color, r.last_result));
                return;
            end
            e = pending_verdicts.pop_front();
            if (r.box_index !== e.box_index || r.light_color !== e.light_color ||
                r.last_result !== e.last_result)
                report($sformatf("verdict box %0d/%0d color %0d/%0d last %0b/%0b (got/exp)",
                                 r.box_index, e.box_index, r.light_color, e.light_color,
                                 r.last_result, e.last_result));
        endtask

        function int pending();
            return pending_verdicts.size();
        endfunction
    endclass

    light_tally tally = new();

    box_hsv_light_color_classifier_core #(
        .MAX_BOXES  (NUM_BOXES),
        .COORD_BITS (COORD_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // transfers seen at the rising edge feed the tally and the watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && !pix_stall)
                tally.note_pixel(pix);
            if (res_valid && !res_stall)
                tally.check_verdict(res);
            if ((pix_valid && !pix_stall) || (res_valid && !res_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
    end

    initial
    begin
        wait (stuck_cycles >= WATCHDOG_LIMIT);
        $display("tb_box_hsv_light_color_classifier_core: done, errors");
        $finish;
    end

    // result side: random stall bursts, one long hold-off on request
    initial
    begin
        int burst;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
                res_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 10);
                res_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                res_stall <= 1'b0;
            end
            else
                res_stall <= 1'b0;
        end
    end

    function automatic logic [4*COORD_W-1:0] pack_box(logic [11:0] l, logic [11:0] t,
                                                    logic [11:0] w, logic [11:0] h);
        return {h, w, t, l};
    endfunction

    function automatic pixel_t make_pixel(logic [7:0] h, logic [7:0] s, logic [7:0] v,
                                          logic [11:0] c, logic [11:0] r, logic e);
        pixel_t p;
        p.hue        = h;
        p.saturation = s;
        p.brightness = v;
        p.column     = c;
        p.row        = r;
        p.frame_end  = e;
        return p;
    endfunction

    function automatic pixel_t random_pixel(int kind);
        pixel_t    p;
        hsv_band_t b;
        case (kind)
            KIND_RED_A:  b = BAND_RED_A;
            KIND_RED_B:  b = BAND_RED_B;
            KIND_YELLOW: b = BAND_YELLOW;
            KIND_GREEN:  b = BAND_GREEN;
            default:     b = BAND_GREEN;
        endcase
        p.hue        = 8'($urandom_range(b.hi_h, b.lo_h));
        p.saturation = 8'($urandom_range(b.hi_s, b.lo_s));
        p.brightness = 8'($urandom_range(b.hi_v, b.lo_v));
        if (kind == KIND_NOISE)
        begin
            p.hue        = 8'($urandom);
            p.saturation = 8'($urandom);
            p.brightness = 8'($urandom);
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            // step one channel just past a band edge
            case ($urandom_range(0, 5))
                0: p.hue        = b.lo_h - 8'd1;
                1: p.hue        = b.hi_h + 8'd1;
                2: p.saturation = b.lo_s - 8'd1;
                3: p.saturation = b.hi_s + 8'd1;
                4: p.brightness = b.lo_v - 8'd1;
                default: p.brightness = b.hi_v + 8'd1;
            endcase
        end
        if ($urandom_range(0, 9) == 0)
        begin
            p.column = 12'($urandom);
            p.row    = 12'($urandom);
        end
        else
        begin
            p.column = 12'($urandom_range(0, 17));
            p.row    = 12'($urandom_range(0, 17));
        end
        p.frame_end = 1'b0;
        return p;
    endfunction

    task automatic send_pixel(pixel_t p);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            pix_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pix_valid <= 1'b1;
        pix       <= p;
        do
            @(posedge clk);
        while (pix_stall);
    endtask

    task automatic pix_off();
        @(negedge clk);
        pix_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        pix_off();
        while (tally.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [INDEX_BITS-1:0] idx, logic [4*COORD_W-1:0] d);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        tally.write_reg(idx, d);
    endtask

    // narrow registers get random upper data bits, which must be ignored
    task automatic setup(logic [2:0] count, logic [4*COORD_W-1:0] b0,
                         logic [4*COORD_W-1:0] b1, logic [4*COORD_W-1:0] b2,
                         logic [4*COORD_W-1:0] b3, logic [IMG_BITS-1:0] w,
                         logic [IMG_BITS-1:0] h);
        logic [4*COORD_W-1:0] d;
        d = (4*COORD_W)'({$urandom, $urandom});
        write_reg(REG_BOX_COUNT, {d[4*COORD_W-1:3], count});
        write_reg(REG_BOX_FIRST, b0);
        write_reg(REG_BOX_FIRST + 3'd1, b1);
        write_reg(REG_BOX_FIRST + 3'd2, b2);
        write_reg(REG_BOX_FIRST + 3'd3, b3);
        d = (4*COORD_W)'({$urandom, $urandom});
        write_reg(REG_IMAGE_WIDTH, {d[4*COORD_W-1:IMG_BITS], w});
        d = (4*COORD_W)'({$urandom, $urandom});
        write_reg(REG_IMAGE_HEIGHT, {d[4*COORD_W-1:IMG_BITS], h});
        write_reg(REG_UNUSED, (4*COORD_W)'({$urandom, $urandom}));
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [4*COORD_W-1:0] random_box();
        if ($urandom_range(0, 9) == 0)
            return (4*COORD_W)'({$urandom, $urandom});
        return pack_box(12'($urandom_range(0, 12)), 12'($urandom_range(0, 12)),
                        12'($urandom_range(0, 10)), 12'($urandom_range(0, 10)));
    endfunction

    function automatic logic [IMG_BITS-1:0] random_extent();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return 13'd4096;
            2:       return '1;
            3:       return IMG_BITS'($urandom);
            default: return IMG_BITS'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic random_setup();
        logic [2:0] count;
        case ($urandom_range(0, 9))
            0:       count = 3'd0;
            1:       count = 3'($urandom_range(5, 7));
            default: count = 3'($urandom_range(1, 4));
        endcase
        setup(count, random_box(), random_box(), random_box(), random_box(),
              random_extent(), random_extent());
    endtask

    // most pixels of a frame share one color so strict winners are common
    task automatic send_frame(int len);
        int     favor;
        pixel_t p;
        favor = $urandom_range(KIND_RED_A, KIND_NOISE);
        for (int k = 0; k < len; k++)
        begin
            p = random_pixel(($urandom_range(0, 9) < 6) ? favor
                                                         : $urandom_range(KIND_RED_A, KIND_NOISE));
            p.frame_end = (k == len - 1);
            send_pixel(p);
        end
    endtask

    initial
    begin
        int phase;
        int sent;
        int len;
        bit paused;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        pix_valid    = 1'b0;
        pix          = '0;
        quiet        = 1'b0;
        long_hold    = 1'b0;
        stuck_cycles = 0;
        paused       = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // band edges, each color and a tie
        wait_drain();
        setup(3'd3, pack_box(0, 0, 4, 4), pack_box(2, 2, 4, 4), pack_box(6, 0, 2, 8),
              '0, 13'd8, 13'd8);
        send_pixel(make_pixel(8'd0, 8'd120, 8'd200, 12'd0, 12'd0, 1'b0));
        send_pixel(make_pixel(8'd10, 8'd255, 8'd255, 12'd3, 12'd3, 1'b0));
        send_pixel(make_pixel(8'd179, 8'd255, 8'd255, 12'd3, 12'd3, 1'b0));
        send_pixel(make_pixel(8'd25, 8'd140, 8'd200, 12'd3, 12'd3, 1'b0));
        send_pixel(make_pixel(8'd35, 8'd225, 8'd255, 12'd5, 12'd5, 1'b0));
        send_pixel(make_pixel(8'd40, 8'd130, 8'd200, 12'd6, 12'd1, 1'b0));
        send_pixel(make_pixel(8'd80, 8'd245, 8'd255, 12'd7, 12'd7, 1'b1));
        // hue past 179, a near miss and a frame end far outside every box
        send_pixel(make_pixel(8'd30, 8'd200, 8'd220, 12'd4, 12'd4, 1'b0));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 12'd0, 12'd0, 1'b0));
        send_pixel(make_pixel(8'd11, 8'd120, 8'd200, 12'd1, 12'd1, 1'b0));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 12'd4095, 12'd4095, 1'b1));

        // no boxes: frame end gives nothing
        wait_drain();
        setup(3'd0, pack_box(0, 0, 4, 4), pack_box(2, 2, 4, 4), pack_box(6, 0, 2, 8),
              '0, 13'd8, 13'd8);
        send_pixel(make_pixel(8'd5, 8'd200, 8'd220, 12'd1, 12'd1, 1'b1));

        // box count above the limit, largest box and image
        wait_drain();
        setup(3'd7, pack_box(0, 0, 4, 4), pack_box(2, 2, 4, 4), pack_box(6, 0, 2, 8),
              '1, '1, '1);
        send_pixel(make_pixel(8'd60, 8'd200, 8'd255, 12'd4095, 12'd4095, 1'b0));
        send_pixel(make_pixel(8'd0, 8'd150, 8'd210, 12'd0, 12'd0, 1'b1));

        // zero image width empties every box
        wait_drain();
        setup(3'd4, pack_box(0, 0, 4, 4), pack_box(2, 2, 4, 4), pack_box(6, 0, 2, 8),
              '1, '0, '1);
        send_pixel(make_pixel(8'd60, 8'd200, 8'd255, 12'd1, 12'd1, 1'b1));

        // box moved in the middle of a frame
        wait_drain();
        setup(3'd1, pack_box(0, 0, 16, 16), '0, '0, '0, 13'd16, 13'd16);
        send_pixel(make_pixel(8'd60, 8'd200, 8'd255, 12'd3, 12'd3, 1'b0));
        send_pixel(make_pixel(8'd50, 8'd140, 8'd210, 12'd12, 12'd12, 1'b0));
        wait_drain();
        setup(3'd1, pack_box(8, 8, 8, 8), '0, '0, '0, 13'd16, 13'd16);
        send_pixel(make_pixel(8'd5, 8'd130, 8'd220, 12'd9, 12'd9, 1'b0));
        send_pixel(make_pixel(8'd175, 8'd130, 8'd220, 12'd10, 12'd10, 1'b1));

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drain();
            random_setup();
            if (phase >= QUIET_PHASE)
                quiet = 1'b1;
            // short frames against a held-off result side fill the chain
            if (phase == PRESSURE_PHASE)
                long_hold = 1'b1;
            sent = 0;
            while (sent < PHASE_PIXELS)
            begin
                len = (phase == PRESSURE_PHASE) ? $urandom_range(1, 2) : $urandom_range(1, 12);
                send_frame(len);
                sent += len;
                if (phase == PAUSE_PHASE && sent >= PHASE_PIXELS / 2 && !paused)
                begin
                    pix_off();
                    while (tally.pending() != 0)
                        @(posedge clk);
                    paused = 1'b1;
                end
            end
        end

        wait_drain();
        if (tally.errors == 0)
            $display("tb_box_hsv_light_color_classifier_core: done, clean");
        else
            $display("tb_box_hsv_light_color_classifier_core: done, errors");
        $finish;
    end

endmodule
